// ===== sv/disc_track_sector_locator_core_macros.svh =====
`ifndef DISC_TRACK_SECTOR_LOCATOR_CORE_MACROS_SVH
`define DISC_TRACK_SECTOR_LOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DTSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define DTSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dtsl_pkg.sv =====
package dtsl_pkg;

  localparam int TRACK_SLOTS = 99;
  localparam int SLOT_W      = $clog2(TRACK_SLOTS);
  localparam int TRK_W       = 7;
  localparam int LBA_W       = 24;
  localparam int OFF_W       = 32;
  localparam int BYTES_W     = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [BYTES_W-1:0] SIZE_COOKED = 12'd2048;
  localparam logic [BYTES_W-1:0] SIZE_RAW    = 12'd2352;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_OPEN  = 2'd0,
    CFG_FIRST_TRACK = 2'd1,
    CFG_LAST_TRACK  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  typedef struct packed {
    logic [4:0] payload;
    logic [1:0] kind;
    logic       raw;
  } fmt_t;

  typedef struct packed {
    logic [LBA_W-1:0] start;
    logic [LBA_W-1:0] length;
    logic [OFF_W-1:0] offset;
    fmt_t             fmt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic wr;
    logic start;
    logic issue;
    logic capture;
    logic mul;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic more;
    logic hit;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== sv/disc_track_sector_locator_core.sv =====
// Table write: taken while the controller is idle, no result word; slots beyond the table are dropped.
// Lookup: one table entry read per cycle over the scanned range up to the first hit, then
// multiply and load; the result word is loaded once the output register is free. One item in
// flight; the next input word is taken only after the result word is loaded.
// Reset (rst_ni low, asynchronous): controller idle, no result pending, image closed,
// scan range empty (first 1, last 0); table contents undefined until written.
module disc_track_sector_locator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dtsl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dtsl_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [dtsl_pkg::TRK_W-1:0]          track_slot_i,
  input  logic [dtsl_pkg::LBA_W-1:0]          start_lba_i,
  input  logic [dtsl_pkg::LBA_W-1:0]          length_sectors_i,
  input  logic [dtsl_pkg::OFF_W-1:0]          image_offset_i,
  input  logic                                sector_is_raw_i,
  input  logic [1:0]                          track_kind_i,
  input  logic [4:0]                          payload_offset_i,
  input  logic [dtsl_pkg::LBA_W-1:0]          lookup_lba_i,
  input  logic                                raw_mode_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic [dtsl_pkg::TRK_W-1:0]          track_number_o,
  output logic [dtsl_pkg::LBA_W-1:0]          sector_index_o,
  output logic [dtsl_pkg::OFF_W-1:0]          byte_offset_o,
  output logic                                synthesise_o,
  output logic [dtsl_pkg::BYTES_W-1:0]        deliver_bytes_o,
  output logic [1:0]                          kind_out_o,
  output logic [4:0]                          payload_out_o
);
  import dtsl_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  dtsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  dtsl_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .track_slot_i     (track_slot_i),
    .start_lba_i      (start_lba_i),
    .length_sectors_i (length_sectors_i),
    .image_offset_i   (image_offset_i),
    .sector_is_raw_i  (sector_is_raw_i),
    .track_kind_i     (track_kind_i),
    .payload_offset_i (payload_offset_i),
    .lookup_lba_i     (lookup_lba_i),
    .raw_mode_i       (raw_mode_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .found_o          (found_o),
    .track_number_o   (track_number_o),
    .sector_index_o   (sector_index_o),
    .byte_offset_o    (byte_offset_o),
    .synthesise_o     (synthesise_o),
    .deliver_bytes_o  (deliver_bytes_o),
    .kind_out_o       (kind_out_o),
    .payload_out_o    (payload_out_o)
  );

endmodule

// ===== sv/dtsl_ram.sv =====
module dtsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dtsl_ctrl.sv =====
module dtsl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                func_i,
  input  dtsl_pkg::ctrl_sts_t sts_i,
  output logic                in_stall_o,
  output dtsl_pkg::ctrl_cmd_t cmd_o
);
  import dtsl_pkg::*;

  state_e state_q, state_d;
  logic   pend_q, pend_d;

  // Hold state and the read-pending flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // Sequence writes, table scan, multiply and result load
  always_comb begin
    state_d    = state_q;
    pend_d     = 1'b0;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (func_e'(func_i) == FUNC_LOOKUP) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (pend_q && sts_i.hit) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end else begin
          cmd_o.issue = sts_i.more;
          pend_d      = sts_i.more;
          if (!sts_i.more && !pend_q) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/dtsl_dp.sv =====
module dtsl_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dtsl_pkg::ctrl_cmd_t                 cmd_i,
  output dtsl_pkg::ctrl_sts_t                 sts_o,
  input  logic                                cfg_valid_i,
  input  logic [dtsl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dtsl_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [dtsl_pkg::TRK_W-1:0]          track_slot_i,
  input  logic [dtsl_pkg::LBA_W-1:0]          start_lba_i,
  input  logic [dtsl_pkg::LBA_W-1:0]          length_sectors_i,
  input  logic [dtsl_pkg::OFF_W-1:0]          image_offset_i,
  input  logic                                sector_is_raw_i,
  input  logic [1:0]                          track_kind_i,
  input  logic [4:0]                          payload_offset_i,
  input  logic [dtsl_pkg::LBA_W-1:0]          lookup_lba_i,
  input  logic                                raw_mode_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic                                found_o,
  output logic [dtsl_pkg::TRK_W-1:0]          track_number_o,
  output logic [dtsl_pkg::LBA_W-1:0]          sector_index_o,
  output logic [dtsl_pkg::OFF_W-1:0]          byte_offset_o,
  output logic                                synthesise_o,
  output logic [dtsl_pkg::BYTES_W-1:0]        deliver_bytes_o,
  output logic [1:0]                          kind_out_o,
  output logic [4:0]                          payload_out_o
);
  import dtsl_pkg::*;

  localparam int PROD_W = LBA_W + BYTES_W;

  // Configuration registers
  logic             open_q;
  logic [TRK_W-1:0] first_q;
  logic [TRK_W-1:0] last_q;

  // Lookup context and scan counter
  logic [LBA_W-1:0] lba_q;
  logic             raw_req_q;
  logic [TRK_W-1:0] n_q;
  logic [TRK_W-1:0] rd_n_q;

  // Captured hit
  logic             hit_q;
  logic [TRK_W-1:0] trk_q;
  logic [LBA_W-1:0] idx_q;
  logic [OFF_W-1:0] off_q;
  fmt_t             fmt_q;
  logic [OFF_W-1:0] prod_q;

  // Output word
  logic             out_valid_q;
  logic             found_q;
  logic [TRK_W-1:0] trk_out_q;
  logic [LBA_W-1:0] idx_out_q;
  logic [OFF_W-1:0] off_out_q;
  logic             synth_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [1:0]       kind_q;
  logic [4:0]       payload_q;

  entry_t           wr_entry;
  entry_t           rd_entry;
  logic             wr_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [TRK_W-1:0] scan_first;
  logic [TRK_W-1:0] scan_last;
  logic [LBA_W:0]   diff;
  logic [BYTES_W-1:0] size;
  logic [PROD_W-1:0] prod_full;

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      first_q <= TRK_W'(1);
      last_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_OPEN:  open_q  <= cfg_data_i[0];
        CFG_FIRST_TRACK: first_q <= cfg_data_i;
        CFG_LAST_TRACK:  last_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Track table store
  assign wr_en    = cmd_i.wr && (track_slot_i < TRK_W'(TRACK_SLOTS));
  assign wr_entry = '{start:   start_lba_i,
                      length:  length_sectors_i,
                      offset:  image_offset_i,
                      fmt:     '{payload: payload_offset_i,
                                 kind:    track_kind_i,
                                 raw:     sector_is_raw_i}};
  assign rd_addr  = SLOT_W'(n_q - TRK_W'(1));

  dtsl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TRACK_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (track_slot_i[SLOT_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  // Clip the scan range to the table
  assign scan_first = (first_q == '0) ? TRK_W'(1) : first_q;
  assign scan_last  = (last_q > TRK_W'(TRACK_SLOTS)) ? TRK_W'(TRACK_SLOTS) : last_q;

  // Range test on the entry just read
  assign diff      = {1'b0, lba_q} - {1'b0, rd_entry.start};
  assign sts_o.hit = !diff[LBA_W] && (diff[LBA_W-1:0] < rd_entry.length);
  assign sts_o.more     = (n_q <= scan_last);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // Sector size of the captured track
  assign size      = fmt_q.raw ? SIZE_RAW : SIZE_COOKED;
  assign prod_full = {{BYTES_W{1'b0}}, idx_q} * {{LBA_W{1'b0}}, size};

  // Lookup context, scan counter and hit capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      lba_q     <= lookup_lba_i;
      raw_req_q <= raw_mode_i;
      n_q       <= scan_first;
    end
    if (cmd_i.issue) begin
      rd_n_q <= n_q;
      n_q    <= n_q + TRK_W'(1);
    end
    if (cmd_i.capture) begin
      trk_q <= rd_n_q;
      idx_q <= diff[LBA_W-1:0];
      off_q <= rd_entry.offset;
      fmt_q <= rd_entry.fmt;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[OFF_W-1:0];
    end
  end

  // Track whether this lookup found a track
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.start) begin
      hit_q <= 1'b0;
    end else if (cmd_i.capture) begin
      hit_q <= 1'b1;
    end
  end

  // Output word valid: set on load, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload; all zero on a miss
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      found_q <= hit_q;
      if (hit_q) begin
        trk_out_q <= trk_q;
        idx_out_q <= idx_q;
        off_out_q <= off_q + prod_q;
        synth_q   <= !fmt_q.raw;
        bytes_q   <= open_q ? (raw_req_q ? SIZE_RAW : SIZE_COOKED) : '0;
        kind_q    <= fmt_q.kind;
        payload_q <= fmt_q.payload;
      end else begin
        trk_out_q <= '0;
        idx_out_q <= '0;
        off_out_q <= '0;
        synth_q   <= 1'b0;
        bytes_q   <= '0;
        kind_q    <= '0;
        payload_q <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign track_number_o  = trk_out_q;
  assign sector_index_o  = idx_out_q;
  assign byte_offset_o   = off_out_q;
  assign synthesise_o    = synth_q;
  assign deliver_bytes_o = bytes_q;
  assign kind_out_o      = kind_q;
  assign payload_out_o   = payload_q;

endmodule

// ===== sv/dtsl_checker.sv =====
`include "disc_track_sector_locator_core_macros.svh"

module dtsl_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                func_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                found_o,
  input logic [dtsl_pkg::TRK_W-1:0]          track_number_o,
  input logic [dtsl_pkg::OFF_W-1:0]          byte_offset_o,
  input logic [dtsl_pkg::BYTES_W-1:0]        deliver_bytes_o
);
  import dtsl_pkg::*;

  // A stalled result word holds
  `DTSL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(byte_offset_o), "stalled result word changed")

  // A miss reports no track and no bytes
  `DTSL_ASSERT_NOW(a_miss_zero, out_valid_o && !found_o, track_number_o == '0 && deliver_bytes_o == '0, "miss word carries data")

  // A hit names a real track
  `DTSL_ASSERT_NOW(a_hit_track, out_valid_o && found_o, track_number_o != '0, "hit word has track zero")

  // Delivered count is one of the two sector sizes or zero
  `DTSL_ASSERT_NOW(a_bytes_legal, out_valid_o, deliver_bytes_o == '0 || deliver_bytes_o == SIZE_RAW || deliver_bytes_o == SIZE_COOKED, "bad delivered byte count")

  // A lookup keeps the input busy in the next cycle
  `DTSL_ASSERT_NEXT(a_lookup_busy, in_valid_i && !in_stall_o && func_i, in_stall_o, "input not busy after lookup")

endmodule

bind disc_track_sector_locator_core dtsl_checker u_dtsl_checker (.*);

// ===== tb/sv/sector_lookup_checker.sv =====
`timescale 1ns / 100ps

module sector_lookup_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [dtsl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dtsl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            func_i,
  input  logic [dtsl_pkg::TRK_W-1:0]      track_slot_i,
  input  logic [dtsl_pkg::LBA_W-1:0]      start_lba_i,
  input  logic [dtsl_pkg::LBA_W-1:0]      length_sectors_i,
  input  logic [dtsl_pkg::OFF_W-1:0]      image_offset_i,
  input  logic                            sector_is_raw_i,
  input  logic [1:0]                      track_kind_i,
  input  logic [4:0]                      payload_offset_i,
  input  logic [dtsl_pkg::LBA_W-1:0]      lookup_lba_i,
  input  logic                            raw_mode_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            found_i,
  input  logic [dtsl_pkg::TRK_W-1:0]      track_number_i,
  input  logic [dtsl_pkg::LBA_W-1:0]      sector_index_i,
  input  logic [dtsl_pkg::OFF_W-1:0]      byte_offset_i,
  input  logic                            synthesise_i,
  input  logic [dtsl_pkg::BYTES_W-1:0]    deliver_bytes_i,
  input  logic [1:0]                      kind_out_i,
  input  logic [4:0]                      payload_out_i,
  output int                              mismatch_count_o,
  output int                              results_due_o
);
  import dtsl_pkg::*;

  typedef struct packed {
    logic               found;
    logic [TRK_W-1:0]   track;
    logic [LBA_W-1:0]   index;
    logic [OFF_W-1:0]   offset;
    logic               synth;
    logic [BYTES_W-1:0] bytes;
    logic [1:0]         kind;
    logic [4:0]         payload;
  } sector_loc_t;

  // Shadow copy of the track table and the scan registers
  logic [LBA_W-1:0] start_tab  [TRACK_SLOTS];
  logic [LBA_W-1:0] length_tab [TRACK_SLOTS];
  logic [OFF_W-1:0] offset_tab [TRACK_SLOTS];
  fmt_t             format_tab [TRACK_SLOTS];
  logic             image_open;
  logic [TRK_W-1:0] first_scanned;
  logic [TRK_W-1:0] last_scanned;

  sector_loc_t lookup_results_due[$];
  sector_loc_t want;
  sector_loc_t got;

  // Scan the configured track numbers in order and take the first one holding the LBA
  function automatic sector_loc_t locate_sector(logic [LBA_W-1:0] lba, logic raw_req);
    sector_loc_t      loc;
    logic [LBA_W:0]   range_end;
    logic [OFF_W-1:0] size;
    int               s;
    loc = '0;
    for (int n = int'(first_scanned); n <= int'(last_scanned) && !loc.found; n++) begin
      if (n >= 1 && n <= TRACK_SLOTS) begin
        s = n - 1;
        // range end is one bit wider: no wrap past the top of the LBA space
        range_end = {1'b0, start_tab[s]} + {1'b0, length_tab[s]};
        if (lba >= start_tab[s] && {1'b0, lba} < range_end) begin
          size        = format_tab[s].raw ? OFF_W'(SIZE_RAW) : OFF_W'(SIZE_COOKED);
          loc.found   = 1'b1;
          loc.track   = TRK_W'(n);
          loc.index   = lba - start_tab[s];
          loc.offset  = offset_tab[s] + OFF_W'(loc.index) * size;
          loc.synth   = !format_tab[s].raw;
          loc.bytes   = image_open ? (raw_req ? SIZE_RAW : SIZE_COOKED) : '0;
          loc.kind    = format_tab[s].kind;
          loc.payload = format_tab[s].payload;
        end
      end
    end
    return loc;
  endfunction

  task automatic report_mismatch(input sector_loc_t exp_loc, input sector_loc_t act_loc);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("%0t lookup mismatch, expected: found=%0d track=%0d index=%0h offset=%0h",
               $realtime, exp_loc.found, exp_loc.track, exp_loc.index, exp_loc.offset);
      $display("    synth=%0d bytes=%0d kind=%0d payload=%0d",
               exp_loc.synth, exp_loc.bytes, exp_loc.kind, exp_loc.payload);
      $display("  actual: found=%0d track=%0d index=%0h offset=%0h",
               act_loc.found, act_loc.track, act_loc.index, act_loc.offset);
      $display("    synth=%0d bytes=%0d kind=%0d payload=%0d",
               act_loc.synth, act_loc.bytes, act_loc.kind, act_loc.payload);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_open    = 1'b0;
      first_scanned = TRK_W'(1);
      last_scanned  = '0;
      lookup_results_due.delete();
      results_due_o = 0;
    end else begin
      // Retire a result word against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got = {found_i, track_number_i, sector_index_i, byte_offset_i, synthesise_i,
               deliver_bytes_i, kind_out_i, payload_out_i};
        if (lookup_results_due.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t result word with no lookup waiting: found=%0d track=%0d",
                     $realtime, got.found, got.track);
        end else begin
          want = lookup_results_due.pop_front();
          if (got !== want) report_mismatch(want, got);
        end
      end

      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_OPEN:  image_open    = cfg_data_i[0];
          CFG_FIRST_TRACK: first_scanned = cfg_data_i;
          CFG_LAST_TRACK:  last_scanned  = cfg_data_i;
          default: ;
        endcase
      end

      // Take an input word: store an entry or predict a lookup
      if (in_valid_i && !in_stall_i) begin
        if (func_e'(func_i) == FUNC_LOOKUP) begin
          lookup_results_due.push_back(locate_sector(lookup_lba_i, raw_mode_i));
        end else if (int'(track_slot_i) < TRACK_SLOTS) begin
          start_tab[track_slot_i]  = start_lba_i;
          length_tab[track_slot_i] = length_sectors_i;
          offset_tab[track_slot_i] = image_offset_i;
          format_tab[track_slot_i] = '{payload: payload_offset_i, kind: track_kind_i,
                                       raw: sector_is_raw_i};
        end
      end

      results_due_o = lookup_results_due.size();
    end
  end

endmodule

// ===== tb/sv/tb_disc_track_sector_locator_core.sv =====
`timescale 1ns / 100ps

module tb_disc_track_sector_locator_core;
  import dtsl_pkg::*;

  // Longest scan is 99 table entries plus the multiply and load steps
  localparam int SETTLE_CYCLES   = 140;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 92;

  typedef struct packed {
    func_e            func;
    logic [TRK_W-1:0] slot;
    logic [LBA_W-1:0] start;
    logic [LBA_W-1:0] len;
    logic [OFF_W-1:0] offset;
    logic             raw;
    logic [1:0]       kind;
    logic [4:0]       payload;
    logic [LBA_W-1:0] lba;
    logic             raw_req;
  } track_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  func_i;
  logic [TRK_W-1:0]      track_slot_i;
  logic [LBA_W-1:0]      start_lba_i;
  logic [LBA_W-1:0]      length_sectors_i;
  logic [OFF_W-1:0]      image_offset_i;
  logic                  sector_is_raw_i;
  logic [1:0]            track_kind_i;
  logic [4:0]            payload_offset_i;
  logic [LBA_W-1:0]      lookup_lba_i;
  logic                  raw_mode_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  found_o;
  logic [TRK_W-1:0]      track_number_o;
  logic [LBA_W-1:0]      sector_index_o;
  logic [OFF_W-1:0]      byte_offset_o;
  logic                  synthesise_o;
  logic [BYTES_W-1:0]    deliver_bytes_o;
  logic [1:0]            kind_out_o;
  logic [4:0]            payload_out_o;

  int mismatch_count;
  int results_due;
  int send_idle_pct;
  int recv_stall_pct;

  // Stimulus-side view of the table, used only to aim lookups and keep scans on loaded slots
  logic [LBA_W-1:0] track_start_seen [TRACK_SLOTS];
  logic [LBA_W-1:0] track_len_seen   [TRACK_SLOTS];
  bit               slot_loaded      [TRACK_SLOTS];
  logic [TRK_W-1:0] scan_first;
  logic [TRK_W-1:0] scan_last;

  disc_track_sector_locator_core uut (.*);

  sector_lookup_checker checker_inst (
    .clk_i, .rst_ni, .cfg_valid_i,
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .in_valid_i,
    .in_stall_i       (in_stall_o),
    .func_i, .track_slot_i, .start_lba_i, .length_sectors_i, .image_offset_i,
    .sector_is_raw_i, .track_kind_i, .payload_offset_i, .lookup_lba_i, .raw_mode_i,
    .out_valid_i      (out_valid_o),
    .out_stall_i,
    .found_i          (found_o),
    .track_number_i   (track_number_o),
    .sector_index_i   (sector_index_o),
    .byte_offset_i    (byte_offset_o),
    .synthesise_i     (synthesise_o),
    .deliver_bytes_i  (deliver_bytes_o),
    .kind_out_i       (kind_out_o),
    .payload_out_i    (payload_out_o),
    .mismatch_count_o (mismatch_count),
    .results_due_o    (results_due)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Offer one word, idling first at random, and hold it until taken
  task automatic push_word(input track_word_t w);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    func_i           = w.func;
    track_slot_i     = w.slot;
    start_lba_i      = w.start;
    length_sectors_i = w.len;
    image_offset_i   = w.offset;
    sector_is_raw_i  = w.raw;
    track_kind_i     = w.kind;
    payload_offset_i = w.payload;
    lookup_lba_i     = w.lba;
    raw_mode_i       = w.raw_req;
    in_valid_i       = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_track(input logic [TRK_W-1:0] slot, input logic [LBA_W-1:0] start,
                             input logic [LBA_W-1:0] len, input logic [OFF_W-1:0] offset,
                             input logic raw, input logic [1:0] kind,
                             input logic [4:0] payload);
    track_word_t w;
    w = '{func: FUNC_WRITE, slot: slot, start: start, len: len, offset: offset, raw: raw,
          kind: kind, payload: payload, lba: LBA_W'($urandom), raw_req: 1'($urandom)};
    if (int'(slot) < TRACK_SLOTS) begin
      track_start_seen[slot] = start;
      track_len_seen[slot]   = len;
      slot_loaded[slot]      = 1'b1;
    end
    push_word(w);
  endtask

  // Mostly disc-sized tracks; now and then empty, huge, near the top, or overlapping
  task automatic random_track(input logic [TRK_W-1:0] slot);
    logic [LBA_W-1:0] start;
    logic [LBA_W-1:0] len;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 70) start = LBA_W'($urandom_range(0, 360000));
    else if (r < 82 && slot != 0 && int'(slot) <= TRACK_SLOTS && slot_loaded[slot-1])
      start = track_start_seen[slot-1] + LBA_W'($urandom_range(0, 100));
    else if (r < 92) start = LBA_W'($urandom_range(16777215 - 5000, 16777215));
    else start = LBA_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 75) len = LBA_W'($urandom_range(1, 4500));
    else if (r < 85) len = '0;
    else len = LBA_W'($urandom);
    write_track(slot, start, len, $urandom, 1'($urandom), 2'($urandom), 5'($urandom));
  endtask

  task automatic lookup(input logic [LBA_W-1:0] lba, input logic raw_req);
    track_word_t w;
    w = '{func: FUNC_LOOKUP, slot: TRK_W'($urandom), start: LBA_W'($urandom),
          len: LBA_W'($urandom), offset: $urandom, raw: 1'($urandom), kind: 2'($urandom),
          payload: 5'($urandom), lba: lba, raw_req: raw_req};
    push_word(w);
  endtask

  function automatic int scan_lo();
    return (scan_first < 1) ? 1 : int'(scan_first);
  endfunction

  function automatic int scan_hi();
    return (scan_last > TRACK_SLOTS) ? TRACK_SLOTS : int'(scan_last);
  endfunction

  // Aim mostly inside or at the edges of a scanned track, otherwise anywhere
  function automatic logic [LBA_W-1:0] pick_lba();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (scan_lo() > scan_hi() || r < 15) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        default: return LBA_W'($urandom);
      endcase
    end
    s = $urandom_range(scan_lo(), scan_hi()) - 1;
    if (track_len_seen[s] == 0 || r < 35) begin
      case ($urandom_range(0, 3))
        0:       return track_start_seen[s] - 1'b1;
        1:       return track_start_seen[s];
        2:       return track_start_seen[s] + track_len_seen[s] - 1'b1;
        default: return track_start_seen[s] + track_len_seen[s];
      endcase
    end
    return track_start_seen[s] + LBA_W'($urandom_range(0, int'(track_len_seen[s]) - 1));
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drain the block, then change the scan setup
  task automatic configure(input logic open, input logic [TRK_W-1:0] first,
                           input logic [TRK_W-1:0] last);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(CFG_IMAGE_OPEN, {6'($urandom), open});
    write_reg(CFG_FIRST_TRACK, first);
    write_reg(CFG_LAST_TRACK, last);
    scan_first = first;
    scan_last  = last;
  endtask

  // Load every scanned slot not yet written
  task automatic fill_scan_range();
    for (int n = scan_lo(); n <= scan_hi(); n++)
      if (!slot_loaded[n-1]) random_track(TRK_W'(n - 1));
  endtask

  task automatic run_phase(input int phase);
    int r;
    int sent;
    case (phase)
      0:       configure(1'b1, 7'd1, 7'd4);
      1:       configure(1'b0, 7'd2, 7'd8);
      2:       configure(1'b1, 7'd0, 7'd12);
      3:       configure(1'b1, 7'd5, 7'd5);
      4:       configure(1'b1, 7'd1, 7'd99);
      5:       configure(1'b0, 7'd1, 7'd99);
      6:       configure(1'b1, 7'd90, 7'd127);
      7:       configure(1'b1, 7'd99, 7'd127);
      8:       configure(1'b1, 7'd0, 7'd127);
      default: configure(1'($urandom), TRK_W'($urandom_range(0, 99)),
                         TRK_W'($urandom_range(0, 127)));
    endcase
    case (phase % 4)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
    fill_scan_range();
    sent = 0;
    while (sent < ITEMS_PER_PHASE) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // out-of-table slot: the block drops it, so it does not count
        random_track(TRK_W'($urandom_range(TRACK_SLOTS, 127)));
      end else if (r < 35) begin
        if (r < 25 && scan_lo() <= scan_hi())
          random_track(TRK_W'($urandom_range(scan_lo(), scan_hi()) - 1));
        else
          random_track(TRK_W'($urandom_range(0, TRACK_SLOTS - 1)));
        sent++;
      end else begin
        lookup(pick_lba(), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_IMAGE_OPEN;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    func_i           = FUNC_WRITE;
    track_slot_i     = '0;
    start_lba_i      = '0;
    length_sectors_i = '0;
    image_offset_i   = '0;
    sector_is_raw_i  = 1'b0;
    track_kind_i     = '0;
    payload_offset_i = '0;
    lookup_lba_i     = '0;
    raw_mode_i       = 1'b0;
    out_stall_i      = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    scan_first       = 7'd1;
    scan_last        = 7'd0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: overlap, full-length track, empty track, ignored slots
    configure(1'b1, 7'd1, 7'd3);
    write_track(7'd0, 24'd0, 24'd150, 32'd0, 1'b1, 2'd0, 5'd0);
    write_track(7'd1, 24'd100, 24'hFFFFFF, 32'hFFFF_FF00, 1'b0, 2'd3, 5'd31);
    write_track(7'd2, 24'hFFFFFF, 24'd0, 32'hFFFF_FFFF, 1'b1, 2'd2, 5'd24);
    write_track(7'd99, 24'd0, 24'hFFFFFF, 32'd0, 1'b0, 2'd1, 5'd1);
    write_track(7'd127, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b1, 2'd3, 5'd31);
    lookup(24'd0, 1'b1);
    lookup(24'd149, 1'b0);
    lookup(24'd150, 1'b1);
    lookup(24'd100, 1'b0);
    lookup(24'd99, 1'b1);
    lookup(24'hFFFFFF, 1'b1);
    lookup(24'hFFFFFE, 1'b0);
    // image closed, track number zero in the scan
    configure(1'b0, 7'd0, 7'd2);
    lookup(24'd0, 1'b1);
    lookup(24'h123456, 1'b1);
    // empty scan range
    configure(1'b1, 7'd3, 7'd2);
    lookup(24'd120, 1'b1);
    // zero-length track only
    configure(1'b1, 7'd3, 7'd3);
    lookup(24'hFFFFFF, 1'b0);
    // scan wholly above the table
    configure(1'b1, 7'd100, 7'd127);
    lookup(24'd0, 1'b1);

    for (int p = 0; p < PHASES; p++) run_phase(p);

    // Drain, then allow the block's latency to pass
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("tb_disc_track_sector_locator_core: PASS");
    end else begin
      $display("tb_disc_track_sector_locator_core: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("tb_disc_track_sector_locator_core: FAIL");
    $finish;
  end

endmodule
